/* sv/siph_pkg.sv */
// Shared types, constants and round function for the SipHash-2-4 stream block.
`timescale 1ns / 1ps

package siph_pkg;

    localparam int MSG_W   = 64;
    localparam int TAIL_W  = 3;
    localparam int LEN_W   = 8;
    localparam int TDATA_W = 72;

    localparam logic [63:0] INIT_A    = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_B    = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C    = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_D    = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    // configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // finalisation request from the absorb stage
    typedef struct packed {
        logic   valid;
        t_lanes lanes;
    } t_fin_req;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        t_lanes w;
        w   = v;
        w.a = w.a + w.b;
        w.b = rotl(w.b, 13);
        w.b = w.b ^ w.a;
        w.a = rotl(w.a, 32);
        w.c = w.c + w.d;
        w.d = rotl(w.d, 16);
        w.d = w.d ^ w.c;
        w.a = w.a + w.d;
        w.d = rotl(w.d, 21);
        w.d = w.d ^ w.a;
        w.c = w.c + w.b;
        w.b = rotl(w.b, 17);
        w.b = w.b ^ w.c;
        w.c = rotl(w.c, 32);
        return w;
    endfunction

endpackage

/* sv/siph_core.sv */
// Lane state and word absorption (two rounds per word) for SipHash-2-4.
`timescale 1ns / 1ps

module siph_core import siph_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [63:0]          i_key_low,
    input  logic [63:0]          i_key_high,
    input  logic                 i_step,
    input  logic [MSG_W-1:0]     i_word,
    input  logic [TAIL_W-1:0]    i_tail,
    input  logic                 i_last,
    output t_fin_req             o_fin
);

    t_lanes             r_lanes;
    logic [LEN_W-1:0]   r_len;
    logic               r_in_msg;

    t_lanes             start_lanes;
    t_lanes             absorbed;
    logic [LEN_W-1:0]   start_len;
    logic [LEN_W-1:0]   total_len;
    logic [63:0]        tail_mask;
    logic [63:0]        blk;

    always_comb begin
        if (r_in_msg) begin
            start_lanes = r_lanes;
            start_len   = r_len;
        end else begin
            start_lanes.a = INIT_A ^ i_key_low;
            start_lanes.b = INIT_B ^ i_key_high;
            start_lanes.c = INIT_C ^ i_key_low;
            start_lanes.d = INIT_D ^ i_key_high;
            start_len     = '0;
        end

        total_len = start_len + LEN_W'(i_tail);
        // all-zero mask when no tail bytes
        tail_mask = (64'd1 << {i_tail, 3'b000}) - 64'd1;

        if (i_last) begin
            blk = {total_len, i_word[55:0] & tail_mask[55:0]};
        end else begin
            blk = i_word;
        end

        absorbed   = start_lanes;
        absorbed.d = absorbed.d ^ blk;
        absorbed   = sip_round(absorbed);
        absorbed   = sip_round(absorbed);
        absorbed.a = absorbed.a ^ blk;

        o_fin.valid   = i_step & i_last;
        o_fin.lanes   = absorbed;
        o_fin.lanes.c = absorbed.c ^ FINAL_XOR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes  <= '0;
            r_len    <= '0;
            r_in_msg <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_len    <= '0;
                r_in_msg <= 1'b0;
            end else begin
                r_lanes  <= absorbed;
                r_len    <= start_len + LEN_W'(8);
                r_in_msg <= 1'b1;
            end
        end
    end

endmodule

/* sv/siph_final.sv */
// Finalisation pipeline: four rounds over two stages, then the digest register.
`timescale 1ns / 1ps

module siph_final import siph_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_fin_req     i_req,
    output logic         o_ready,
    output logic         o_tvalid,
    input  logic         i_tready,
    output logic [63:0]  o_digest
);

    logic         r_v1;
    t_lanes       r_l1;
    logic         r_v2;
    t_lanes       r_l2;
    logic         r_vo;
    logic [63:0]  r_dig;

    logic         out_free;
    logic         s2_mv;
    logic         s2_free;
    logic         s1_mv;
    t_lanes       n_l2;
    t_lanes       fin_l;
    logic [63:0]  n_dig;

    always_comb begin
        out_free = !r_vo || i_tready;
        s2_mv    = r_v2 && out_free;
        s2_free  = !r_v2 || s2_mv;
        s1_mv    = r_v1 && s2_free;
        o_ready  = !r_v1 || s1_mv;

        n_l2  = sip_round(sip_round(r_l1));
        fin_l = sip_round(sip_round(r_l2));
        n_dig = fin_l.a ^ fin_l.b ^ fin_l.c ^ fin_l.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_req.valid || (r_v1 && !s1_mv);
            r_v2 <= s1_mv || (r_v2 && !s2_mv);
            r_vo <= s2_mv || (r_vo && !i_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_l1 <= i_req.lanes;
        end
        if (s1_mv) begin
            r_l2 <= n_l2;
        end
        if (s2_mv) begin
            r_dig <= n_dig;
        end
    end

    assign o_tvalid = r_vo;
    assign o_digest = r_dig;

endmodule

/* sv/siphash_2_4_stream.sv */
// SipHash-2-4 over a stream of 64-bit message words: top level.
// Usage:
//  - Key halves k0 and k1 are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//    (index 0 = k0, index 1 = k1) while no message is in flight.
//  - Message words arrive on the s_axis channel, first byte in bits 7:0.
//    Every non-last request carries eight bytes; the request with tlast set
//    carries 0 to 7 trailing bytes, their count in tdata[66:64].
//  - The first request after reset or after a tlast opens a new message and
//    loads the lanes from the key registers at the moment it is absorbed.
//  - One digest per message leaves on m_axis.
// Timing: one request accepted every cycle, for any mix of word and last
// requests, while no last request waits for room in finalisation. A word is
// absorbed (two rounds) the cycle after acceptance; the digest of a last
// request takes the four finishing rounds split over two pipeline stages.
// Reset clears the key, the lane state and all valid flags.
// A stalled m_axis holds the digest; up to three finished messages queue in
// the finalisation stages before s_axis_tready drops.
`timescale 1ns / 1ps

module siphash_2_4_stream import siph_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [63:0]         i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // [63:0] msg_word, [66:64] tail_bytes, rest 0
    input  logic                s_axis_tlast,   // last
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata    // [63:0] digest
);

    logic [63:0]        r_key_low;
    logic [63:0]        r_key_high;
    logic               r_v0;
    logic [MSG_W-1:0]   r_word;
    logic [TAIL_W-1:0]  r_tail;
    logic               r_last;

    logic               in_acc;
    logic               s0_adv;
    logic               fin_ready;
    t_fin_req           fin_req;

    assign s0_adv        = r_v0 && (!r_last || fin_ready);
    assign s_axis_tready = !r_v0 || s0_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= in_acc || (r_v0 && !s0_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= s_axis_tdata[MSG_W-1:0];
            r_tail <= s_axis_tdata[MSG_W+TAIL_W-1:MSG_W];
            r_last <= s_axis_tlast;
        end
    end

    siph_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_step     (s0_adv),
        .i_word     (r_word),
        .i_tail     (r_tail),
        .i_last     (r_last),
        .o_fin      (fin_req)
    );

    siph_final u_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fin_req),
        .o_ready  (fin_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_digest (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // a last request only leaves the input register when finalisation has room
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_req.valid |-> fin_ready)
        else $error("finalisation request while stage busy");

    // a stalled digest keeps its value until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // after reset nothing is pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");
`endif

endmodule
